@@ sv/bsr_pkg.sv @@
`default_nettype none

package bsr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_W  = 7;

  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  // register indexes on the configuration port
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    MODE_PUSH    = 2'd0,
    MODE_POP     = 2'd1,
    MODE_PEEK    = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                     mode;
    logic signed [WORD_W-1:0]  push_value;
  } bsr_cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  top_value;
    status_e                   status;
    logic                      is_full;
    logic                      is_empty;
  } bsr_res_t;

endpackage

`default_nettype wire

@@ sv/bsr_ram.sv @@
`default_nettype none

module bsr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/bounded_stack_with_reverse_unit.sv @@
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+-------------------------------
// request   | start, busy, cmd_i                      | taken when start & !busy
// result    | done_o, res_o                           | one-cycle strobe, no stall
// config    | psel, penable, pwrite, paddr, pwdata,   | apb write, pready tied high
//           | prdata, pready                          |
//
// push and peek need no ram read; pop of a stack with two or more entries
// goes through S_POP_RD (new top read back from the ram); reverse of n entries swaps
// floor(n/2) pairs, each costing two reads and two writes on the single ram port pair.
// the result strobe is registered: it comes in the cycle after the request's last cycle.
// reset clears the entry count and sets the capacity register to 64; ram contents are
// not cleared. the receiver cannot stall; busy stays high while a request is in work.
`default_nettype none

module bounded_stack_with_reverse_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  bsr_pkg::bsr_cmd_t  cmd_i,
  output logic               done_o,
  output bsr_pkg::bsr_res_t  res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import bsr_pkg::*;

  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CAP_W = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_RD_LO,
    S_RD_HI,
    S_WR_LO,
    S_WR_HI
  } state_e;

  state_e                   state_q;
  logic [CW-1:0]            count_q;
  logic signed [WORD_W-1:0] top_q;
  logic [WORD_W-1:0]        tmp_q;
  logic [AW-1:0]            lo_q;
  logic [AW-1:0]            hi_q;
  logic                     done_q;
  bsr_res_t                 res_q;
  logic [CFG_W-1:0]         cap_q;

  logic                     accept;
  logic [CAP_W-1:0]         cap_ext;
  logic [CAP_W-1:0]         eff_cap;
  logic                     full_now;
  logic [CW-1:0]            cnt_m1;
  logic [CW-1:0]            cnt_m2;
  logic [AW:0]              lo_p2;
  logic                     more_pairs;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [WORD_W-1:0]        ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;

  function automatic bsr_res_t make_res(logic [CW-1:0] cnt, logic [WORD_W-1:0] top,
                                        status_e st, logic [CAP_W-1:0] cap);
    bsr_res_t r;
    r.top_value = (cnt == '0) ? '0 : top;
    r.status    = st;
    r.is_full   = CAP_W'(cnt) >= cap;
    r.is_empty  = (cnt == '0);
    return r;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      cap_q <= pwdata[CFG_W-1:0];
    end
  end

  // capacity saturated to 1..depth
  assign cap_ext  = CAP_W'(cap_q);
  assign eff_cap  = (cap_q == '0) ? CAP_W'(1) : ((cap_ext > DEPTH_C) ? DEPTH_C : cap_ext);
  assign full_now = CAP_W'(count_q) >= eff_cap;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign cnt_m1     = count_q - CW'(1);
  assign cnt_m2     = count_q - CW'(2);
  assign lo_p2      = {1'b0, lo_q} + (AW+1)'(2);
  assign more_pairs = lo_p2 < {1'b0, hi_q};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lo_q;
    ram_wdata = ram_rdata;
    ram_raddr = lo_q;
    case (state_q)
      S_IDLE: begin
        ram_waddr = count_q[AW-1:0];
        ram_wdata = cmd_i.push_value;
        ram_raddr = cnt_m2[AW-1:0];
        ram_we    = accept && (cmd_i.mode == MODE_PUSH) && !full_now;
      end
      S_RD_LO: ram_raddr = lo_q;
      S_RD_HI: ram_raddr = hi_q;
      S_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q;
        ram_wdata = ram_rdata;
      end
      S_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = tmp_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  bsr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      top_q   <= '0;
      tmp_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (cmd_i.mode)
              MODE_PUSH: begin
                done_q <= 1'b1;
                if (full_now) begin
                  res_q <= make_res(count_q, top_q, ST_OVERFLOW, eff_cap);
                end else begin
                  count_q <= count_q + CW'(1);
                  top_q   <= cmd_i.push_value;
                  res_q   <= make_res(count_q + CW'(1), cmd_i.push_value, ST_OK, eff_cap);
                end
              end
              MODE_POP: begin
                if (count_q == '0) begin
                  done_q <= 1'b1;
                  res_q  <= make_res(count_q, top_q, ST_UNDERFLOW, eff_cap);
                end else if (cnt_m1 == '0) begin
                  done_q  <= 1'b1;
                  count_q <= '0;
                  res_q   <= make_res('0, top_q, ST_OK, eff_cap);
                end else begin
                  // new top comes back from the ram next cycle
                  count_q <= cnt_m1;
                  state_q <= S_POP_RD;
                end
              end
              MODE_PEEK: begin
                done_q <= 1'b1;
                res_q  <= make_res(count_q, top_q,
                                   (count_q == '0) ? ST_UNDERFLOW : ST_OK, eff_cap);
              end
              MODE_REVERSE: begin
                if ((count_q == '0) || (cnt_m1 == '0)) begin
                  done_q <= 1'b1;
                  res_q  <= make_res(count_q, top_q, ST_OK, eff_cap);
                end else begin
                  lo_q    <= '0;
                  hi_q    <= cnt_m1[AW-1:0];
                  state_q <= S_RD_LO;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_POP_RD: begin
          top_q   <= ram_rdata;
          done_q  <= 1'b1;
          res_q   <= make_res(count_q, ram_rdata, ST_OK, eff_cap);
          state_q <= S_IDLE;
        end
        S_RD_LO: state_q <= S_RD_HI;
        S_RD_HI: begin
          tmp_q <= ram_rdata;
          // bottom entry becomes the new top
          if (lo_q == '0) begin
            top_q <= ram_rdata;
          end
          state_q <= S_WR_LO;
        end
        S_WR_LO: state_q <= S_WR_HI;
        S_WR_HI: begin
          if (more_pairs) begin
            lo_q    <= lo_q + AW'(1);
            hi_q    <= hi_q - AW'(1);
            state_q <= S_RD_LO;
          end else begin
            done_q  <= 1'b1;
            res_q   <= make_res(count_q, top_q, ST_OK, eff_cap);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ sv/bsr_checker.sv @@
`default_nettype none

module bsr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input bsr_pkg::bsr_cmd_t  cmd_i,
  input logic               done_o,
  input bsr_pkg::bsr_res_t  res_o
);

  import bsr_pkg::*;

  // a finished request never overlaps a request still in work
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // push and peek answer in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ((cmd_i.mode == MODE_PUSH) || (cmd_i.mode == MODE_PEEK))) |=> done_o)
    else $error("push or peek result missing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.is_empty) |-> ((res_o.top_value == '0) && !res_o.is_full))
    else $error("empty stack reports a top or full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == ST_OVERFLOW)) |-> res_o.is_full)
    else $error("overflow without full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == ST_UNDERFLOW)) |-> res_o.is_empty)
    else $error("underflow on a non-empty stack");

endmodule

bind bounded_stack_with_reverse_unit bsr_checker u_bsr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .cmd_i  (cmd_i),
  .done_o (done_o),
  .res_o  (res_o)
);

`default_nettype wire
